[rtl/core/sfa_pkg.sv]
// Shared types and constants of the spring force accumulator.
// Field layout of the stream beats, command codes, queue entry and engine states.
// No dependencies.
package sfa_pkg;

  localparam int IDX_W     = 10;
  localparam int COORD_W   = 32;
  localparam int GRP_W     = 16;
  localparam int LEN_W     = 31;
  localparam int DAMP_W    = 17;
  localparam int FORCE_W   = 48;

  localparam int S_TDATA_W = 216;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 160;

  localparam int IDXA_LSB  = 0;
  localparam int IDXB_LSB  = 10;
  localparam int X_LSB     = 20;
  localparam int Y_LSB     = 52;
  localparam int Z_LSB     = 84;
  localparam int GRP_LSB   = 116;
  localparam int REST_LSB  = 132;
  localparam int STIFF_LSB = 163;
  localparam int DAMP_LSB  = 194;

  localparam logic [DAMP_W-1:0] ONE_Q = 17'h10000;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_LOAD_POS   = 2'd0,
    CMD_LOAD_VEL   = 2'd1,
    CMD_SPRING     = 2'd2,
    CMD_READ_FORCE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                      cmd;
    logic [IDX_W-1:0]          idx_a;
    logic [IDX_W-1:0]          idx_b;
    logic [COORD_W-1:0]        x;
    logic [COORD_W-1:0]        y;
    logic [COORD_W-1:0]        z;
    logic [GRP_W-1:0]          group;
    logic [LEN_W-1:0]          rest;
    logic [LEN_W-1:0]          stiff;
    logic [DAMP_W-1:0]         undamp;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qslot_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_OUT,
    ST_SP_RDB,
    ST_SP_DIFF,
    ST_SQ_MUL,
    ST_SQ_ADD,
    ST_SQRT,
    ST_DIR_DIV,
    ST_STRAIN_DIV,
    ST_T1_MUL,
    ST_T1_USE,
    ST_RV_MUL,
    ST_RV_ADD,
    ST_T2_MUL,
    ST_T2_USE,
    ST_F_MUL_HI,
    ST_F_MUL_LO,
    ST_F_USE,
    ST_ACC_RDA,
    ST_ACC_WRA,
    ST_ACC_WRB
  } state_t;

endpackage

[rtl/core/sfa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/sfa_front.sv]
// Front end: accepts input beats, unpacks and classifies them, reduces body indices
// and clamps damping, then pushes one entry into the command queue. Uses sfa_pkg.
module sfa_front #(
  parameter int BODY_COUNT = 1024
) (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sfa_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [sfa_pkg::S_TUSER_W-1:0] s_tuser,
  input  logic                         q_full,
  input  logic                         clearing,
  output sfa_pkg::qslot_t              push
);
  import sfa_pkg::*;

  function automatic logic [IDX_W-1:0] reduce_idx(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    r = v;
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if ((BODY_COUNT << k) < (1 << IDX_W)) begin
        if (r >= IDX_W'(BODY_COUNT << k)) begin
          r = r - IDX_W'(BODY_COUNT << k);
        end
      end
    end
    return r;
  endfunction

  logic [DAMP_W-1:0] damp;

  assign s_tready = !q_full && !clearing;
  assign damp     = s_tdata[DAMP_LSB +: DAMP_W];

  always_comb begin
    push.valid       = s_tvalid && s_tready;
    push.item.cmd    = cmd_t'(s_tuser);
    push.item.idx_a  = reduce_idx(s_tdata[IDXA_LSB +: IDX_W]);
    push.item.idx_b  = reduce_idx(s_tdata[IDXB_LSB +: IDX_W]);
    push.item.x      = s_tdata[X_LSB +: COORD_W];
    push.item.y      = s_tdata[Y_LSB +: COORD_W];
    push.item.z      = s_tdata[Z_LSB +: COORD_W];
    push.item.group  = s_tdata[GRP_LSB +: GRP_W];
    push.item.rest   = s_tdata[REST_LSB +: LEN_W];
    push.item.stiff  = s_tdata[STIFF_LSB +: LEN_W];
    push.item.undamp = (damp > ONE_Q) ? '0 : ONE_Q - damp;
  end

endmodule

[rtl/core/sfa_queue.sv]
// Short command queue between front end and engine.
// Uses sfa_pkg for the entry type and depth.
module sfa_queue (
  input  logic            clk,
  input  logic            rst,
  input  sfa_pkg::qslot_t push,
  output logic            full,
  output sfa_pkg::qslot_t head,
  input  logic            pop
);
  import sfa_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == (PW+1)'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/sfa_back.sv]
// Engine: executes queued commands against the body tables, one at a time.
// Holds the group mask register, body RAMs, shared multiplier, sqrt and divider.
// Uses sfa_pkg and sfa_ram.
module sfa_back #(
  parameter int BODY_COUNT = 1024,
  parameter int GROUP_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sfa_pkg::GRP_W-1:0]     cfg_wr_data,
  input  sfa_pkg::qslot_t               head,
  output logic                          pop,
  output logic                          clearing,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [sfa_pkg::M_TDATA_W-1:0] m_tdata
);
  import sfa_pkg::*;

  localparam int AW         = $clog2(BODY_COUNT);
  localparam int GW         = (GROUP_BITS < GRP_W) ? GROUP_BITS : GRP_W;
  localparam int POS_W      = 3 * COORD_W + GW;
  localparam int VEL_W      = 3 * COORD_W;
  localparam int ACC_W      = 3 * FORCE_W;
  localparam int SQRT_LAST  = 33;
  localparam int DIV_LAST   = 51;

  function automatic logic [FORCE_W-1:0] sat_add(input logic [FORCE_W-1:0] a,
                                                 input logic [FORCE_W-1:0] b);
    logic [FORCE_W:0] sm;
    sm = {a[FORCE_W-1], a} + {b[FORCE_W-1], b};
    if (sm[FORCE_W] != sm[FORCE_W-1]) begin
      return sm[FORCE_W] ? {1'b1, {(FORCE_W-1){1'b0}}} : {1'b0, {(FORCE_W-1){1'b1}}};
    end
    return sm[FORCE_W-1:0];
  endfunction

  state_t state, state_next;
  item_t  cur;

  logic [GRP_W-1:0] grp_mask;
  logic [AW-1:0]    clr_addr;

  logic             pos_we, vel_we, acc_we;
  logic [AW-1:0]    pos_waddr, acc_waddr, rd_addr, acc_raddr;
  logic [POS_W-1:0] pos_wdata, pos_rdata, a_pos;
  logic [VEL_W-1:0] vel_wdata, vel_rdata, a_vel;
  logic [ACC_W-1:0] acc_wdata, acc_rdata;

  logic [32:0] d [3];
  logic [32:0] dv [3];
  logic [32:0] cd [3];
  logic [32:0] cdv [3];
  logic [32:0] dmag [3];
  logic [32:0] dvmag [3];
  logic [17:0] dir [3];
  logic [16:0] dirmag [3];
  logic [47:0] f [3];
  logic [1:0]  k;
  logic [5:0]  cnt;
  logic        gok;

  logic [65:0] sq_sum, sq_sum_nx;
  logic [67:0] sr_rad;
  logic [35:0] sr_rem, rem_nx;
  logic [33:0] sr_root, root_nx, trial;
  logic [37:0] rem_sh;
  logic        sq_ge;

  logic [33:0] len;
  logic [51:0] dnum, dquo, dquo_nx;
  logic [33:0] dden, drem, drem_nx;
  logic [34:0] dsh;
  logic        dge;
  logic [34:0] lr;
  logic [33:0] lrmag;

  logic [31:0] e, emag;
  logic [47:0] t1, s, t1m, t2m, fm;
  logic [46:0] smag;
  logic [51:0] rv_sum, rvmag, rv_p;
  logic [39:0] hi_prod;
  logic [63:0] fsum;

  logic [33:0] mul_a, mul_b;
  logic [67:0] prod;
  logic        out_free;

  sfa_ram #(.WIDTH(POS_W), .DEPTH(BODY_COUNT)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
    .raddr(rd_addr), .rdata(pos_rdata)
  );

  sfa_ram #(.WIDTH(VEL_W), .DEPTH(BODY_COUNT)) u_vel_ram (
    .clk(clk), .we(vel_we), .waddr(pos_waddr), .wdata(vel_wdata),
    .raddr(rd_addr), .rdata(vel_rdata)
  );

  sfa_ram #(.WIDTH(ACC_W), .DEPTH(BODY_COUNT)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rdata)
  );

  // arithmetic helpers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cd[i]     = {a_pos[i*COORD_W + COORD_W-1], a_pos[i*COORD_W +: COORD_W]}
                - {pos_rdata[i*COORD_W + COORD_W-1], pos_rdata[i*COORD_W +: COORD_W]};
      cdv[i]    = {a_vel[i*COORD_W + COORD_W-1], a_vel[i*COORD_W +: COORD_W]}
                - {vel_rdata[i*COORD_W + COORD_W-1], vel_rdata[i*COORD_W +: COORD_W]};
      dmag[i]   = d[i][32] ? 33'(-d[i]) : d[i];
      dvmag[i]  = dv[i][32] ? 33'(-dv[i]) : dv[i];
      dirmag[i] = dir[i][17] ? 17'(-dir[i]) : dir[i][16:0];
    end
    gok = |(a_pos[POS_W-1 -: GW] & pos_rdata[POS_W-1 -: GW] & grp_mask[GW-1:0]);

    sq_sum_nx = sq_sum + 66'(prod);

    rem_sh  = {sr_rem, sr_rad[67:66]};
    trial   = {sr_root[31:0], 2'b01};
    sq_ge   = rem_sh >= 38'(trial);
    rem_nx  = sq_ge ? 36'(rem_sh - 38'(trial)) : rem_sh[35:0];
    root_nx = {sr_root[32:0], sq_ge};

    dsh     = {drem, dnum[51]};
    dge     = dsh >= {1'b0, dden};
    drem_nx = dge ? 34'(dsh - {1'b0, dden}) : dsh[33:0];
    dquo_nx = {dquo[50:0], dge};

    lr    = {1'b0, len} - {4'b0, cur.rest};
    lrmag = lr[34] ? 34'(-lr) : lr[33:0];

    emag  = e[31] ? (32'd0 - e) : e;
    smag  = s[47] ? 47'(-s) : s[46:0];
    rvmag = rv_sum[51] ? (52'd0 - rv_sum) : rv_sum;
    rv_p  = 52'(prod[48:0]);
    t1m   = 48'(prod[63:16]);
    t2m   = 48'(prod[51:16]);
    fsum  = {hi_prod, 24'b0} + 64'(prod[40:0]);
    fm    = 48'(fsum[63:16]);

    case (state)
      ST_SQ_MUL: begin
        mul_a = 34'(dmag[k]);
        mul_b = 34'(dmag[k]);
      end
      ST_T1_MUL: begin
        mul_a = 34'(emag);
        mul_b = 34'(cur.stiff);
      end
      ST_RV_MUL: begin
        mul_a = 34'(dirmag[k]);
        mul_b = 34'(dvmag[k]);
      end
      ST_T2_MUL: begin
        mul_a = rvmag[49:16];
        mul_b = 34'(cur.undamp);
      end
      ST_F_MUL_HI: begin
        mul_a = 34'(smag[46:24]);
        mul_b = 34'(dirmag[k]);
      end
      ST_F_MUL_LO: begin
        mul_a = 34'(smag[23:0]);
        mul_b = 34'(dirmag[k]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:      if (clr_addr == AW'(BODY_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (head.valid) begin
          if (head.item.cmd == CMD_SPRING) begin
            state_next = ST_SP_RDB;
          end else if (head.item.cmd == CMD_READ_FORCE) begin
            state_next = ST_RD_OUT;
          end
        end
      end
      ST_RD_OUT:     if (out_free) state_next = ST_IDLE;
      ST_SP_RDB:     state_next = ST_SP_DIFF;
      ST_SP_DIFF:    state_next = gok ? ST_SQ_MUL : ST_IDLE;
      ST_SQ_MUL:     state_next = ST_SQ_ADD;
      ST_SQ_ADD:     state_next = (k == 2'd2) ? ST_SQRT : ST_SQ_MUL;
      ST_SQRT: begin
        if (cnt == 6'(SQRT_LAST)) begin
          state_next = (root_nx == '0 || cur.rest == '0) ? ST_IDLE : ST_DIR_DIV;
        end
      end
      ST_DIR_DIV:    if (cnt == 6'(DIV_LAST) && k == 2'd2) state_next = ST_STRAIN_DIV;
      ST_STRAIN_DIV: if (cnt == 6'(DIV_LAST)) state_next = ST_T1_MUL;
      ST_T1_MUL:     state_next = ST_T1_USE;
      ST_T1_USE:     state_next = ST_RV_MUL;
      ST_RV_MUL:     state_next = ST_RV_ADD;
      ST_RV_ADD:     state_next = (k == 2'd2) ? ST_T2_MUL : ST_RV_MUL;
      ST_T2_MUL:     state_next = ST_T2_USE;
      ST_T2_USE:     state_next = ST_F_MUL_HI;
      ST_F_MUL_HI:   state_next = ST_F_MUL_LO;
      ST_F_MUL_LO:   state_next = ST_F_USE;
      ST_F_USE:      state_next = (k == 2'd2) ? ST_ACC_RDA : ST_F_MUL_HI;
      ST_ACC_RDA:    state_next = ST_ACC_WRA;
      ST_ACC_WRA:    state_next = ST_ACC_WRB;
      ST_ACC_WRB:    state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs and memory control
  always_comb begin
    out_free  = !m_tvalid || m_tready;
    clearing  = (state == ST_CLEAR);
    pop       = (state == ST_IDLE) && head.valid;
    pos_we    = pop && (head.item.cmd == CMD_LOAD_POS);
    vel_we    = pop && (head.item.cmd == CMD_LOAD_VEL);
    pos_waddr = AW'(head.item.idx_a);
    pos_wdata = {head.item.group[GW-1:0], head.item.z, head.item.y, head.item.x};
    vel_wdata = {head.item.z, head.item.y, head.item.x};
    rd_addr   = (state == ST_SP_RDB) ? AW'(cur.idx_b) : AW'(head.item.idx_a);
    acc_we    = 1'b0;
    acc_waddr = AW'(cur.idx_a);
    acc_wdata = '0;
    acc_raddr = AW'(cur.idx_a);
    unique case (state)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr;
      end
      ST_IDLE: begin
        acc_we    = pos_we;
        acc_waddr = AW'(head.item.idx_a);
        acc_raddr = AW'(head.item.idx_a);
      end
      ST_ACC_WRA: begin
        acc_we    = 1'b1;
        acc_raddr = AW'(cur.idx_b);
        for (int i = 0; i < 3; i++) begin
          acc_wdata[i*FORCE_W +: FORCE_W] = sat_add(acc_rdata[i*FORCE_W +: FORCE_W],
                                                    48'd0 - f[i]);
        end
      end
      ST_ACC_WRB: begin
        acc_we    = 1'b1;
        acc_waddr = AW'(cur.idx_b);
        for (int i = 0; i < 3; i++) begin
          acc_wdata[i*FORCE_W +: FORCE_W] = sat_add(acc_rdata[i*FORCE_W +: FORCE_W], f[i]);
        end
      end
      default: begin
        acc_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      grp_mask <= '1;
      m_tvalid <= 1'b0;
      k        <= '0;
      cnt      <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        grp_mask <= cfg_wr_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_RD_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_SP_DIFF: k <= '0;
        ST_SQ_ADD, ST_RV_ADD, ST_F_USE: k <= (k == 2'd2) ? 2'd0 : k + 1'b1;
        ST_SQRT: begin
          cnt <= (cnt == 6'(SQRT_LAST)) ? '0 : cnt + 1'b1;
        end
        ST_DIR_DIV: begin
          if (cnt == 6'(DIV_LAST)) begin
            cnt <= '0;
            k   <= (k == 2'd2) ? 2'd0 : k + 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_STRAIN_DIV: cnt <= (cnt == 6'(DIV_LAST)) ? '0 : cnt + 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          cur <= head.item;
        end
      end
      ST_RD_OUT: begin
        if (out_free) begin
          m_tdata <= {6'b0, acc_rdata, cur.idx_a};
        end
      end
      ST_SP_RDB: begin
        a_pos <= pos_rdata;
        a_vel <= vel_rdata;
      end
      ST_SP_DIFF: begin
        d      <= cd;
        dv     <= cdv;
        sq_sum <= '0;
      end
      ST_SQ_ADD: begin
        sq_sum <= sq_sum_nx;
        if (k == 2'd2) begin
          sr_rad  <= {2'b0, sq_sum_nx};
          sr_rem  <= '0;
          sr_root <= '0;
        end
      end
      ST_SQRT: begin
        sr_rad  <= {sr_rad[65:0], 2'b0};
        sr_rem  <= rem_nx;
        sr_root <= root_nx;
        if (cnt == 6'(SQRT_LAST)) begin
          len  <= root_nx;
          dnum <= {3'b0, dmag[0], 16'b0};
          dden <= root_nx;
          drem <= '0;
          dquo <= '0;
        end
      end
      ST_DIR_DIV: begin
        if (cnt == 6'(DIV_LAST)) begin
          dir[k] <= d[k][32] ? (18'd0 - 18'(dquo_nx)) : 18'(dquo_nx);
          drem   <= '0;
          dquo   <= '0;
          if (k == 2'd2) begin
            dnum <= {2'b0, lrmag, 16'b0};
            dden <= 34'(cur.rest);
          end else begin
            dnum <= {3'b0, (k == 2'd1) ? dmag[2] : dmag[1], 16'b0};
          end
        end else begin
          dnum <= {dnum[50:0], 1'b0};
          drem <= drem_nx;
          dquo <= dquo_nx;
        end
      end
      ST_STRAIN_DIV: begin
        dnum <= {dnum[50:0], 1'b0};
        drem <= drem_nx;
        dquo <= dquo_nx;
        if (cnt == 6'(DIV_LAST)) begin
          if (lr[34]) begin
            e <= (dquo_nx > 52'h8000_0000) ? 32'h8000_0000 : (32'd0 - dquo_nx[31:0]);
          end else begin
            e <= (dquo_nx > 52'h7FFF_FFFF) ? 32'h7FFF_FFFF : dquo_nx[31:0];
          end
          rv_sum <= '0;
        end
      end
      ST_T1_USE: t1 <= e[31] ? (48'd0 - t1m) : t1m;
      ST_RV_ADD: rv_sum <= (dir[k][17] ^ dv[k][32]) ? rv_sum - rv_p : rv_sum + rv_p;
      ST_T2_USE: s <= t1 + (rv_sum[51] ? (48'd0 - t2m) : t2m);
      ST_F_MUL_LO: hi_prod <= prod[39:0];
      ST_F_USE: f[k] <= (s[47] ^ dir[k][17]) ? (48'd0 - fm) : fm;
      default: begin
        cur <= cur;
      end
    endcase
  end

endmodule

[rtl/core/spring_force_accumulator_unit.sv]
// Spring force accumulator, top level: front end, command queue and engine.
// Uses sfa_pkg, sfa_front, sfa_queue and sfa_back.
//
// Input channel s_*: one beat per command (tuser = command code). Load position,
// load velocity, spring and read force give no output beat except read force,
// which returns one beat on m_* with the body index and its three forces.
// Configuration: cfg_wr_en/cfg_wr_data write the spring group mask (reset 0xFFFF).
// Timing: a load is written as it leaves the queue in the engine's idle state; a read
// force passes through ST_RD_OUT, which waits for the output register to be free and
// then registers its beat. A spring that passes the group check runs 34 square-root
// steps plus four 52-step divisions in one shared radix-2 divider, 14 passes
// through the shared multiplier and a read-modify-write of both force
// accumulators on the single accumulator port. A zero length or zero rest length
// ends it after the square root, and a failed group check ends it at ST_SP_DIFF.
// The front end queues up to 2 commands while the engine works.
// Reset: clears control state, then sweeps the accumulator memory to zero, one body
// per cycle; s_tready stays low during the sweep.
// Stall: a held output beat keeps the engine at that read until m_tready rises.
module spring_force_accumulator_unit #(
  parameter int BODY_COUNT = 1024,
  parameter int GROUP_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [sfa_pkg::GRP_W-1:0]     cfg_wr_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // index_a, index_b, coord_x, coord_y, coord_z, group_bits, rest_length,
  // stiffness, damping, zero pad
  input  logic [sfa_pkg::S_TDATA_W-1:0] s_tdata,
  // command
  input  logic [sfa_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // body_index, force_x, force_y, force_z, zero pad
  output logic [sfa_pkg::M_TDATA_W-1:0] m_tdata
);
  import sfa_pkg::*;

  qslot_t push;
  qslot_t head;
  logic   q_full;
  logic   pop;
  logic   clearing;

  sfa_front #(.BODY_COUNT(BODY_COUNT)) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push)
  );

  sfa_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  sfa_back #(.BODY_COUNT(BODY_COUNT), .GROUP_BITS(GROUP_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .pop         (pop),
    .clearing    (clearing),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

[rtl/core/sfa_checker.sv]
// Port-level checks of the spring force accumulator, bound to the top level.
// Uses sfa_pkg for the output beat width.
module sfa_checker #(
  parameter int BODY_COUNT = 1024
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sfa_pkg::M_TDATA_W-1:0] m_tdata
);

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  a_rst_sweep: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during accumulator sweep");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[9:0] < BODY_COUNT))
    else $error("output body index out of range");

endmodule

bind spring_force_accumulator_unit sfa_checker #(.BODY_COUNT(BODY_COUNT)) u_sfa_checker (.*);
